/* src/i2c_mbe_pkg.sv */
package i2c_mbe_pkg;

  localparam int unsigned DelayBits = 16;
  localparam logic [DelayBits-1:0] HalfPeriodReset = DelayBits'(100);
  localparam int unsigned ByteBits = 8;

  typedef enum logic [1:0] {
    ACT_TICK  = 2'd0,
    ACT_WRITE = 2'd1,
    ACT_READ  = 2'd2,
    ACT_NONE  = 2'd3
  } action_e;

  typedef enum logic [3:0] {
    PH_IDLE  = 4'd0,
    PH_BEGIN = 4'd1,
    PH_RS_D1 = 4'd2,
    PH_RS_W  = 4'd3,
    PH_RS_D2 = 4'd4,
    PH_ST_D  = 4'd5,
    PH_WB_D1 = 4'd6,
    PH_WB_D2 = 4'd7,
    PH_WB_W  = 4'd8,
    PH_RB_D1 = 4'd9,
    PH_RB_W  = 4'd10,
    PH_RB_D2 = 4'd11,
    PH_SP_D1 = 4'd12,
    PH_SP_W  = 4'd13,
    PH_SP_D2 = 4'd14,
    PH_SP_D3 = 4'd15
  } phase_e;

  typedef struct packed {
    action_e             action;
    logic                start_req;
    logic                stop_req;
    logic [ByteBits-1:0] data_byte;
    logic                send_nack;
    logic                scl_level;
    logic                sda_level;
  } item_t;

  typedef struct packed {
    logic                scl_drive_low;
    logic                sda_drive_low;
    logic                busy_res;
    logic                done_res;
    logic [ByteBits-1:0] rx_byte;
    logic                nack_received;
    logic                arb_loss;
  } result_t;

  typedef struct packed {
    phase_e               phase;
    logic [3:0]           bit_count;
    logic [ByteBits-1:0]  shift_reg;
    logic [DelayBits-1:0] delay_count;
    logic                 transfer_open;
    logic                 arb_flag;
    logic                 cf_start;
    logic                 cf_stop;
    logic                 cf_nack;
    logic                 cf_read;
    logic                 scl_low;
    logic                 sda_low;
    logic [ByteBits-1:0]  rx_hold;
    logic                 ack_hold;
  } eng_state_t;

endpackage

/* src/i2c_mbe_step.sv */
module i2c_mbe_step import i2c_mbe_pkg::*; (
  input  eng_state_t           state_i,
  input  item_t                item_i,
  input  logic [DelayBits-1:0] half_period_i,
  output eng_state_t           state_o,
  output result_t              result_o
);

  logic [DelayBits-1:0] dly;
  eng_state_t s;
  logic do_begin, do_after, do_start, done, arb_rep, wait_over, bit_wr, bit_val;

  assign dly = (half_period_i == '0) ? DelayBits'(1) : half_period_i;

  always_comb begin
    s = state_i;
    do_begin = 1'b0;
    do_after = 1'b0;
    do_start = 1'b0;
    done = 1'b0;
    arb_rep = 1'b0;
    wait_over = 1'b0;
    bit_wr = 1'b0;
    bit_val = 1'b0;

    if (item_i.action == ACT_WRITE || item_i.action == ACT_READ) begin
      if (state_i.phase == PH_IDLE) begin
        s.cf_start = item_i.start_req;
        s.cf_stop = item_i.stop_req;
        s.cf_nack = item_i.send_nack;
        s.cf_read = (item_i.action == ACT_READ);
        s.shift_reg = (item_i.action == ACT_READ) ? '0 : item_i.data_byte;
        s.bit_count = '0;
        s.phase = PH_BEGIN;
      end
    end else if (item_i.action == ACT_TICK && state_i.phase != PH_IDLE) begin
      case (state_i.phase)
        PH_RS_W, PH_WB_W, PH_RB_W, PH_SP_W: wait_over = item_i.scl_level;
        PH_BEGIN: wait_over = 1'b1;
        default: begin
          if (state_i.delay_count > DelayBits'(1)) begin
            s.delay_count = state_i.delay_count - DelayBits'(1);
          end else begin
            wait_over = 1'b1;
          end
        end
      endcase
    end

    if (wait_over) begin
      unique case (state_i.phase)
        PH_BEGIN: begin
          if (!state_i.cf_read && state_i.cf_start) begin
            if (state_i.transfer_open) begin
              s.sda_low = 1'b0;
              s.delay_count = dly;
              s.phase = PH_RS_D1;
            end else begin
              do_start = 1'b1;
            end
          end else begin
            do_begin = 1'b1;
          end
        end
        PH_RS_D1: begin
          s.scl_low = 1'b0;
          s.phase = PH_RS_W;
        end
        PH_RS_W: begin
          s.delay_count = dly;
          s.phase = PH_RS_D2;
        end
        PH_RS_D2: do_start = 1'b1;
        PH_ST_D: begin
          s.scl_low = 1'b1;
          s.transfer_open = 1'b1;
          do_begin = 1'b1;
        end
        PH_WB_D1: begin
          s.scl_low = 1'b0;
          s.delay_count = dly;
          s.phase = PH_WB_D2;
        end
        PH_WB_D2: s.phase = PH_WB_W;
        PH_WB_W: begin
          if (!state_i.sda_low && !item_i.sda_level) s.arb_flag = 1'b1;
          s.scl_low = 1'b1;
          if (!state_i.cf_read) s.shift_reg = {state_i.shift_reg[ByteBits-2:0], 1'b0};
          do_after = 1'b1;
        end
        PH_RB_D1: begin
          s.scl_low = 1'b0;
          s.phase = PH_RB_W;
        end
        PH_RB_W: begin
          s.delay_count = dly;
          s.phase = PH_RB_D2;
        end
        PH_RB_D2: begin
          if (state_i.cf_read) begin
            s.shift_reg = {state_i.shift_reg[ByteBits-2:0], item_i.sda_level};
            if (state_i.bit_count == 4'd7) s.rx_hold = s.shift_reg;
          end else begin
            s.ack_hold = item_i.sda_level;
          end
          s.scl_low = 1'b1;
          do_after = 1'b1;
        end
        PH_SP_D1: begin
          s.scl_low = 1'b0;
          s.phase = PH_SP_W;
        end
        PH_SP_W: begin
          s.delay_count = dly;
          s.phase = PH_SP_D2;
        end
        PH_SP_D2: begin
          s.sda_low = 1'b0;
          s.delay_count = dly;
          s.phase = PH_SP_D3;
        end
        PH_SP_D3: begin
          if (!item_i.sda_level) s.arb_flag = 1'b1;
          s.transfer_open = 1'b0;
          done = 1'b1;
        end
        default: s.phase = PH_IDLE;
      endcase
    end

    if (do_start) begin
      if (!item_i.sda_level) s.arb_flag = 1'b1;
      s.sda_low = 1'b1;
      s.delay_count = dly;
      s.phase = PH_ST_D;
    end

    if (do_after) begin
      s.bit_count = state_i.bit_count + 4'd1;
      if (s.bit_count <= 4'd8) begin
        do_begin = 1'b1;
      end else if (state_i.cf_stop) begin
        s.sda_low = 1'b1;
        s.delay_count = dly;
        s.phase = PH_SP_D1;
      end else begin
        done = 1'b1;
      end
    end

    if (do_begin) begin
      bit_wr = state_i.cf_read ? (s.bit_count == 4'd8) : (s.bit_count < 4'd8);
      bit_val = state_i.cf_read ? state_i.cf_nack : s.shift_reg[ByteBits-1];
      s.sda_low = bit_wr ? !bit_val : 1'b0;
      s.delay_count = dly;
      s.phase = bit_wr ? PH_WB_D1 : PH_RB_D1;
    end

    if (done) begin
      s.phase = PH_IDLE;
      arb_rep = s.arb_flag;
      s.arb_flag = 1'b0;
    end
  end

  assign state_o = s;

  always_comb begin
    result_o.scl_drive_low = s.scl_low;
    result_o.sda_drive_low = s.sda_low;
    result_o.busy_res = (s.phase != PH_IDLE);
    result_o.done_res = done;
    result_o.rx_byte = s.rx_hold;
    result_o.nack_received = s.ack_hold;
    result_o.arb_loss = arb_rep;
  end

endmodule

/* src/i2c_master_byte_engine_core.sv */
// An accepted word is first registered in the input register (in_q); its result
// word is then registered in the output register (out_q) and held until taken.
// Throughput: one word per cycle unless m_axis stalls; one state step per word.
// Reset (rst_ni low): engine idle, both lines released, counters and flags
// cleared, half_period_ticks back to 100, no word held on either side.
module i2c_master_byte_engine_core import i2c_mbe_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [DelayBits-1:0] cfg_wdata_i,   // half_period_ticks
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [1:0]           s_axis_tuser,  // action
  // start_req, stop_req, data_byte[7:0], send_nack, scl_level, sda_level, 3'b0
  input  logic [15:0]          s_axis_tdata,
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  // scl_drive_low, sda_drive_low, busy_res, done_res, rx_byte[7:0],
  // nack_received, arb_loss, 2'b0
  output logic [15:0]          m_axis_tdata
);

  logic [DelayBits-1:0] half_period_q;
  logic in_vld_q, out_vld_q, advance;
  item_t in_q, in_d;
  result_t out_q, res;
  eng_state_t state_q, state_d;

  assign advance = in_vld_q && (!out_vld_q || m_axis_tready);
  assign s_axis_tready = !in_vld_q || advance;

  always_comb begin
    in_d.action = action_e'(s_axis_tuser);
    in_d.start_req = s_axis_tdata[0];
    in_d.stop_req = s_axis_tdata[1];
    in_d.data_byte = s_axis_tdata[9:2];
    in_d.send_nack = s_axis_tdata[10];
    in_d.scl_level = s_axis_tdata[11];
    in_d.sda_level = s_axis_tdata[12];
  end

  i2c_mbe_step u_step (
    .state_i      (state_q),
    .item_i       (in_q),
    .half_period_i(half_period_q),
    .state_o      (state_d),
    .result_o     (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      half_period_q <= HalfPeriodReset;
      in_vld_q <= 1'b0;
      out_vld_q <= 1'b0;
      state_q <= '0;
    end else begin
      if (cfg_we_i) half_period_q <= cfg_wdata_i;
      if (s_axis_tready) in_vld_q <= s_axis_tvalid;
      if (advance) begin
        out_vld_q <= 1'b1;
        state_q <= state_d;
      end else if (m_axis_tready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) in_q <= in_d;
    if (advance) out_q <= res;
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata = {2'b00, out_q.arb_loss, out_q.nack_received, out_q.rx_byte,
                         out_q.done_res, out_q.busy_res, out_q.sda_drive_low,
                         out_q.scl_drive_low};

endmodule
